// ===== src/integer_to_radix_string_core_defines.svh =====
// ----------------------------------------------------------------------------
// integer_to_radix_string_core_defines
// assertion macros shared by the radix string core modules
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_STRING_CORE_DEFINES_SVH
`define INTEGER_TO_RADIX_STRING_CORE_DEFINES_SVH

// property must hold at every clock edge outside reset
`define ITOA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ITOA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// shared constants, types and helpers of the radix string core
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

   localparam int WORD_BITS   = 32;
   localparam int RADIX_BITS  = 6;
   localparam int DIGIT_BITS  = 6;
   localparam int CHAR_BITS   = 8;
   localparam int STORE_DEPTH = WORD_BITS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS  = $clog2(STORE_DEPTH + 1);

   // divider retires this many quotient bits per cycle
   localparam int STEP_BITS   = 4;
   localparam int DIV_STEPS   = WORD_BITS / STEP_BITS;
   localparam int STEP_CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_DEC   = 6'd10;

   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 6'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS    = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO     = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_LETTER_A = 8'h41;

   typedef struct packed {
      logic [WORD_BITS-1:0]  magnitude;
      logic                  negative;
      logic [RADIX_BITS-1:0] radix;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_sts_type;

   typedef struct packed {
      logic                  start;
      logic [RADIX_BITS-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // digit value to upper-case ascii
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d < DIGIT_TEN) begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         res = CHAR_LETTER_A + CHAR_BITS'(d) - CHAR_BITS'(DIGIT_TEN);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/itoa_divider.sv =====
// ----------------------------------------------------------------------------
// itoa_divider
// restoring divider, word by radix, a few quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire itoa_pkg::div_ctl_type          ctl,
   input  wire logic [itoa_pkg::WORD_BITS-1:0] dividend,
   output itoa_pkg::div_sts_type               sts,
   output logic [itoa_pkg::WORD_BITS-1:0]      quotient,
   output logic [itoa_pkg::RADIX_BITS-1:0]     remainder
);
   import itoa_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_CNT_BITS-1:0] step_ff, step_in;
   logic [WORD_BITS-1:0]     quo_ff, quo_in;
   logic [RADIX_BITS-1:0]    rem_ff, rem_in;
   logic [RADIX_BITS-1:0]    divisor_ff, divisor_in;

   logic [WORD_BITS-1:0]     quo_step;
   logic [RADIX_BITS-1:0]    rem_step;
   logic [RADIX_BITS:0]      trial;

   // one cycle worth of restoring steps
   always_comb begin
      quo_step = quo_ff;
      rem_step = rem_ff;
      trial    = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial    = {rem_step, quo_step[WORD_BITS-1]};
         quo_step = {quo_step[WORD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_step    = RADIX_BITS'(trial - {1'b0, divisor_ff});
            quo_step[0] = 1'b1;
         end else begin
            rem_step = trial[RADIX_BITS-1:0];
         end
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (ctl.start) begin
         busy_in    = 1'b1;
         step_in    = STEP_CNT_BITS'(DIV_STEPS - 1);
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = ctl.divisor;
      end else if (busy_ff) begin
         quo_in  = quo_step;
         rem_in  = rem_step;
         step_in = step_ff - STEP_CNT_BITS'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/itoa_queue.sv =====
// ----------------------------------------------------------------------------
// itoa_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_radix_string_core_defines.svh"

module itoa_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire itoa_pkg::job_type push_data,
   input  wire logic              pop,
   output itoa_pkg::job_type      pop_data,
   output itoa_pkg::q_sts_type    sts
);
   import itoa_pkg::*;

   job_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign do_push = push && (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = entry_ff[rd_ptr_ff];
   assign sts.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign sts.empty = (count_ff == '0);

   `ITOA_ASSERT_NEVER(a_queue_overrun, clock, reset, count_ff > QCNT_BITS'(QUEUE_DEPTH), "job queue count beyond depth")

endmodule

`default_nettype wire

// ===== src/itoa_front.sv =====
// ----------------------------------------------------------------------------
// itoa_front
// accepts requests, holds the radix register and classifies each value
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   input  wire logic signed [itoa_pkg::WORD_BITS-1:0] req_value,
   output logic                                       req_full,
   input  wire logic                                  csr_valid,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0]       csr_data,
   output logic                                       csr_ready,
   input  wire itoa_pkg::q_sts_type                   q_sts,
   output logic                                       q_push,
   output itoa_pkg::job_type                          q_data
);
   import itoa_pkg::*;

   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [WORD_BITS-1:0]  value_bits;
   logic                  radix_ok;
   logic                  negative;

   assign csr_ready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (csr_valid) begin
         radix_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // only radix 10 is signed; illegal radix drops the request
   assign value_bits = $unsigned(req_value);
   assign radix_ok   = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign negative   = (radix_ff == RADIX_DEC) && value_bits[WORD_BITS-1];

   assign q_data.magnitude = negative ? (~value_bits + WORD_BITS'(1)) : value_bits;
   assign q_data.negative  = negative;
   assign q_data.radix     = radix_ff;

   assign req_full = q_sts.full;
   assign q_push   = req_push && !q_sts.full && radix_ok;

endmodule

`default_nettype wire

// ===== src/itoa_back.sv =====
// ----------------------------------------------------------------------------
// itoa_back
// splits a magnitude into digits and emits the characters
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_radix_string_core_defines.svh"

module itoa_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire itoa_pkg::q_sts_type            q_sts,
   input  wire itoa_pkg::job_type              job,
   output logic                                q_pop,
   input  wire logic                           rsp_pop,
   output logic                                rsp_empty,
   output logic [itoa_pkg::CHAR_BITS-1:0]      rsp_character,
   output logic                                rsp_last
);
   import itoa_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_SIGN = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   neg_ff, neg_in;
   logic [RADIX_BITS-1:0]  radix_ff, radix_in;
   logic                   valid_ff, valid_in;
   logic [CHAR_BITS-1:0]   char_ff, char_in;
   logic                   last_ff, last_in;

   logic [DIGIT_BITS-1:0]  store_mem [STORE_DEPTH];
   logic [DIGIT_BITS-1:0]  rd_data_ff;
   logic                   wr_en, rd_en;
   logic [COUNT_BITS-1:0]  count_less;
   logic [ADDR_BITS-1:0]   wr_addr, rd_addr;

   div_ctl_type            div_ctl;
   div_sts_type            div_sts;
   logic [WORD_BITS-1:0]   dividend;
   logic [WORD_BITS-1:0]   quotient;
   logic [RADIX_BITS-1:0]  remainder;

   logic                   slot_free;
   logic                   load;

   itoa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (dividend),
      .sts       (div_sts),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign slot_free  = !valid_ff || rsp_pop;
   assign count_less = count_ff - COUNT_BITS'(1);
   assign wr_addr    = count_ff[ADDR_BITS-1:0];
   assign rd_addr    = count_less[ADDR_BITS-1:0];

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      neg_in          = neg_ff;
      radix_in        = radix_ff;
      q_pop           = 1'b0;
      div_ctl.start   = 1'b0;
      div_ctl.divisor = radix_ff;
      dividend        = quotient;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      load            = 1'b0;
      char_in         = char_ff;
      last_in         = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_sts.empty) begin
               q_pop           = 1'b1;
               neg_in          = job.negative;
               radix_in        = job.radix;
               count_in        = '0;
               div_ctl.start   = 1'b1;
               div_ctl.divisor = job.radix;
               dividend        = job.magnitude;
               state_in        = S_DIV;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               wr_en    = 1'b1;
               count_in = count_ff + COUNT_BITS'(1);
               if (quotient == '0) begin
                  state_in = neg_ff ? S_SIGN : S_RD;
               end else begin
                  div_ctl.start = 1'b1;
               end
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               load     = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            count_in = count_less;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               load     = 1'b1;
               char_in  = digit_char(rd_data_ff);
               last_in  = (count_ff == '0);
               state_in = (count_ff == '0) ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      valid_in = load || (valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      radix_ff <= radix_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   // digit store, least significant digit at address zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   `ITOA_ASSERT(a_idle_div_quiet, clock, reset, (state_ff == S_IDLE) |-> !div_sts.busy, "divider busy while back end idle")
   `ITOA_ASSERT(a_store_in_range, clock, reset, div_sts.done |-> (count_ff < COUNT_BITS'(STORE_DEPTH)), "digit store overflow")
   `ITOA_ASSERT_NEVER(a_read_empty_store, clock, reset, (state_ff == S_RD) && (count_ff == '0), "digit read with empty store")

endmodule

`default_nettype wire

// ===== src/integer_to_radix_string_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_string_core
// flow: a request waits in the job queue; the back end then divides it digit by digit
//   in the 4-bit-per-cycle divider into the digit store, loads a minus if negative,
//   then for each digit, msd first, does a digit store read and an output load; each load
//   waits for a free output slot; the next job waits for the last character's load
// reset: synchronous, clears control and sets radix to 10; digit store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_string_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request side
   input  wire logic                                  req_push,
   input  wire logic signed [itoa_pkg::WORD_BITS-1:0] req_value,
   output logic                                       req_full,
   // result side
   input  wire logic                                  rsp_pop,
   output logic                                       rsp_empty,
   output logic [itoa_pkg::CHAR_BITS-1:0]             rsp_character,
   output logic                                       rsp_last,
   // radix register write
   input  wire logic                                  csr_valid,
   input  wire logic [itoa_pkg::RADIX_BITS-1:0]       csr_data,
   output logic                                       csr_ready
);
   import itoa_pkg::*;

   // front to queue
   logic      q_push;
   job_type   q_push_data;
   // queue to back
   logic      q_pop;
   job_type   q_pop_data;
   q_sts_type q_sts;

   // front: radix register, sign handling, illegal radix filter
   itoa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_value (req_value),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .q_sts     (q_sts),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // short job queue so requests keep flowing while the back end converts
   itoa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .sts       (q_sts)
   );

   // back: digit split through the divider, then characters msd first
   itoa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_sts         (q_sts),
      .job           (q_pop_data),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
